// ----- sv/mp2_pkg.sv -----
// shared constants for the 2x2 max pooling stream block
// no dependencies

package mp2_pkg;

  localparam int CFG_DATA_BITS  = 9;
  localparam int CFG_INDEX_BITS = 2;
  localparam int COL_CFG_BITS   = 9;
  localparam int ROW_CFG_BITS   = 9;
  localparam int CHAN_CFG_BITS  = 7;

  localparam int OUT_ROW_BITS = 7;
  localparam int OUT_COL_BITS = 7;
  localparam int CHANNEL_BITS = 6;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMNS  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS = 2'd2;

  localparam logic [COL_CFG_BITS-1:0]  COLUMNS_RESET  = 9'd256;
  localparam logic [ROW_CFG_BITS-1:0]  ROWS_RESET     = 9'd256;
  localparam logic [CHAN_CFG_BITS-1:0] CHANNELS_RESET = 7'd64;

endpackage

// ----- sv/mp2_cell.sv -----
// one cell of the pair maximum line: holds one top-row pair maximum
// takes the word of its right neighbor on a shift, or the new word at the tail
// no dependencies

module mp2_cell #(
  parameter int W     = 16,
  parameter int PW    = 7,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                shift,
  input  logic [PW-1:0]       tail,
  input  logic signed [W-1:0] din,
  input  logic signed [W-1:0] from_right,
  output logic signed [W-1:0] value
);

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= (tail == PW'(INDEX)) ? din : from_right;
    end
  end

endmodule

// ----- sv/mp2_line.sv -----
// line of pair maximum cells, shifting toward cell 0 where the head is read
// depends on mp2_cell

module mp2_line #(
  parameter int W  = 16,
  parameter int NP = 128,
  parameter int PW = 7
) (
  input  logic                clk,
  input  logic                shift,
  input  logic [PW-1:0]       tail,
  input  logic signed [W-1:0] din,
  output logic signed [W-1:0] head
);

  logic signed [W-1:0] cell_value [NP];

  for (genvar i = 0; i < NP; i++) begin : g_cell
    if (i == NP - 1) begin : g_end
      mp2_cell #(.W(W), .PW(PW), .INDEX(i)) u_cell (
        .clk        (clk),
        .shift      (shift),
        .tail       (tail),
        .din        (din),
        .from_right (cell_value[i]),
        .value      (cell_value[i])
      );
    end else begin : g_mid
      mp2_cell #(.W(W), .PW(PW), .INDEX(i)) u_cell (
        .clk        (clk),
        .shift      (shift),
        .tail       (tail),
        .din        (din),
        .from_right (cell_value[i+1]),
        .value      (cell_value[i])
      );
    end
  end

  assign head = cell_value[0];

endmodule

// ----- sv/max_pool_2x2_stream.sv -----
// 2x2 stride 2 max pooling over a raster stream of signed pixels
// depends on mp2_pkg and mp2_line
//
// pixel channel: pixel_valid / pixel_ready, one signed pixel per word, column
// by column within a row, row by row within a channel, channel after channel.
// result channel: result_valid / result_ready, one word per 2x2 window with
// max_value, out_row, out_col, channel and last (set on the final window of
// the frame).
// config: cfg_write with cfg_index / cfg_data; index 0 columns, 1 rows,
// 2 channels. a write to any of these restarts the frame at its first pixel;
// other indexes are ignored. write only while the block is idle.
// throughput: one pixel per cycle unless the output stalls. a window's result
// is in the output register in the cycle after its bottom-right pixel is taken.
// the top-row pair maxima sit in a row of MAX_COLUMNS/2 cells that shift by
// one on every pixel pair; a bottom row pair reads the head cell.
// reset: registers return to 256 columns, 256 rows, 64 channels, counters
// to the frame start; no clearing pass is needed.
// receiver stall: pixels that do not close a window are still taken; the
// bottom-right pixel of a window waits until the output register frees.

module max_pool_2x2_stream #(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_ROWS     = 256,
  parameter int MAX_CHANNELS = 64,
  parameter int PIXEL_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [mp2_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [mp2_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   pixel_valid,
  output logic                                   pixel_ready,
  input  logic signed [PIXEL_BITS-1:0]           pixel,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [PIXEL_BITS-1:0]           max_value,
  output logic [mp2_pkg::OUT_ROW_BITS-1:0]       out_row,
  output logic [mp2_pkg::OUT_COL_BITS-1:0]       out_col,
  output logic [mp2_pkg::CHANNEL_BITS-1:0]       channel,
  output logic                                   last
);

  localparam int NP  = (MAX_COLUMNS / 2 > 0) ? MAX_COLUMNS / 2 : 1;
  localparam int PW  = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  function automatic int even_size(input logic [8:0] v, input int maxv);
    int s;
    s = int'(v);
    if (s > maxv) s = maxv;
    s = s - (s % 2);
    if (s < 2) s = 2;
    return s;
  endfunction

  function automatic int chan_size(input logic [6:0] v);
    int s;
    s = int'(v);
    if (s > MAX_CHANNELS) s = MAX_CHANNELS;
    if (s < 1) s = 1;
    return s;
  endfunction

  logic [CW-1:0]  last_col;
  logic [PW-1:0]  last_pair;
  logic [RW-1:0]  last_row;
  logic [CHW-1:0] last_chan;

  logic [CW-1:0]  col_count;
  logic [RW-1:0]  row_count;
  logic [CHW-1:0] chan_count;
  logic signed [PIXEL_BITS-1:0] left_pixel;

  logic accept, produce, end_col, end_row, end_chan, cfg_hit;
  logic signed [PIXEL_BITS-1:0] pair_max, line_head, window_max;
  logic [31:0] row_ext, col_ext, chan_ext;

  assign produce     = col_count[0] & row_count[0];
  assign pixel_ready = !produce || !result_valid || result_ready;
  assign accept      = pixel_valid && pixel_ready;

  assign end_col  = (col_count == last_col);
  assign end_row  = (row_count == last_row);
  assign end_chan = (chan_count == last_chan);

  assign pair_max   = (left_pixel >= pixel) ? left_pixel : pixel;
  assign window_max = (line_head >= pair_max) ? line_head : pair_max;

  assign row_ext  = 32'(row_count) >> 1;
  assign col_ext  = 32'(col_count) >> 1;
  assign chan_ext = 32'(chan_count);

  assign cfg_hit = cfg_write && (cfg_index == mp2_pkg::REG_COLUMNS ||
                                 cfg_index == mp2_pkg::REG_ROWS ||
                                 cfg_index == mp2_pkg::REG_CHANNELS);

  mp2_line #(.W(PIXEL_BITS), .NP(NP), .PW(PW)) u_line (
    .clk   (clk),
    .shift (accept && col_count[0]),
    .tail  (last_pair),
    .din   (pair_max),
    .head  (line_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col  <= CW'(even_size(mp2_pkg::COLUMNS_RESET, MAX_COLUMNS) - 1);
      last_pair <= PW'(even_size(mp2_pkg::COLUMNS_RESET, MAX_COLUMNS) / 2 - 1);
      last_row  <= RW'(even_size(mp2_pkg::ROWS_RESET, MAX_ROWS) - 1);
      last_chan <= CHW'(chan_size(mp2_pkg::CHANNELS_RESET) - 1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mp2_pkg::REG_COLUMNS: begin
          last_col  <= CW'(even_size(cfg_data, MAX_COLUMNS) - 1);
          last_pair <= PW'(even_size(cfg_data, MAX_COLUMNS) / 2 - 1);
        end
        mp2_pkg::REG_ROWS: begin
          last_row <= RW'(even_size(cfg_data, MAX_ROWS) - 1);
        end
        mp2_pkg::REG_CHANNELS: begin
          last_chan <= CHW'(chan_size(cfg_data[mp2_pkg::CHAN_CFG_BITS-1:0]) - 1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      chan_count <= '0;
      left_pixel <= '0;
    end else if (cfg_hit) begin
      col_count  <= '0;
      row_count  <= '0;
      chan_count <= '0;
    end else if (accept) begin
      if (!col_count[0]) begin
        left_pixel <= pixel;
      end
      if (!end_col) begin
        col_count <= col_count + 1'b1;
      end else begin
        col_count <= '0;
        if (!end_row) begin
          row_count <= row_count + 1'b1;
        end else begin
          row_count  <= '0;
          chan_count <= end_chan ? '0 : chan_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && produce) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      max_value <= window_max;
      out_row   <= row_ext[mp2_pkg::OUT_ROW_BITS-1:0];
      out_col   <= col_ext[mp2_pkg::OUT_COL_BITS-1:0];
      channel   <= chan_ext[mp2_pkg::CHANNEL_BITS-1:0];
      last      <= end_col && end_row && end_chan;
    end
  end

  a_window_result: assert property (@(posedge clk) disable iff (rst)
    accept && produce |=> result_valid)
    else $error("window close did not load a result");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> result_valid && !result_ready && produce)
    else $error("pixel input held back without an output stall");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_count <= last_col && row_count <= last_row)
    else $error("position counter beyond frame size");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    chan_count <= last_chan)
    else $error("channel counter beyond channel count");

endmodule
